// ----- rtl/core/tfa_pkg.sv -----
// shared types, constants and sub-tile order tables for the tiled address unit
`timescale 1ns / 1ps
package tfa_pkg;

  // field widths
  localparam int unsigned X_W      = 14;
  localparam int unsigned Y_W      = 13;
  localparam int unsigned ROW_W    = 9;
  localparam int unsigned OFFSET_W = 28;
  localparam int unsigned CFG_IDX_W = 2;

  // row width limit in 4K tiles
  localparam logic [ROW_W-1:0] MAX_ROW_TILES = 9'd256;

  // tile geometry
  localparam int unsigned TILE_ROW_W = 8;   // 4K tile row number
  localparam int unsigned TILE_COL_W = 8;   // 4K tile column inside a row
  localparam int unsigned LOW_W      = 12;  // byte offset inside a 4K tile
  localparam int unsigned TILE_NUM_W = OFFSET_W - LOW_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE_PIXELS   = 2'd0,
    CFG_TILES_PER_ROW = 2'd1
  } cfg_reg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                  x_out_of_row;
    logic [TILE_ROW_W-1:0] tile_row;
    logic [TILE_COL_W-1:0] tile_col;
    logic [LOW_W-1:0]      low_offset;
  } tfa_item_t;

  // sub-tile position for even tile rows, indexed by 2*sub_row + sub_col
  function automatic logic [1:0] order_even(input logic [1:0] idx);
    logic [1:0] pos;
    unique case (idx)
      2'd0: pos = 2'd0;
      2'd1: pos = 2'd3;
      2'd2: pos = 2'd1;
      2'd3: pos = 2'd2;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

  // sub-tile position for odd tile rows
  function automatic logic [1:0] order_odd(input logic [1:0] idx);
    logic [1:0] pos;
    unique case (idx)
      2'd0: pos = 2'd2;
      2'd1: pos = 2'd1;
      2'd2: pos = 2'd3;
      2'd3: pos = 2'd0;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage

// ----- rtl/core/tfa_front.sv -----
// front end: splits a coordinate into tile row, serpentine column and in-tile offset
`timescale 1ns / 1ps
module tfa_front
  import tfa_pkg::*;
(
  input  logic             wide_pixels,
  input  logic [ROW_W-1:0] row_tiles,
  input  logic [X_W-1:0]   pixel_x,
  input  logic [Y_W-1:0]   pixel_y,
  output tfa_item_t        item
);

  logic [X_W:0]        row_limit;
  logic [ROW_W-1:0]    tile_x;
  logic [ROW_W-1:0]    col_rev;
  logic [TILE_ROW_W-1:0] tile_y;
  logic                odd_row;
  logic [1:0]          sub_idx;
  logic [1:0]          sub_pos;
  logic [1:0]          micro_x;
  logic [1:0]          micro_y;
  logic [5:0]          inner;

  // row width in pixels: 32 or 64 pixels per 4K tile
  assign row_limit = wide_pixels ? {1'b0, row_tiles, 5'b0} : {row_tiles, 6'b0};

  // 4K tile coordinates
  assign tile_x  = wide_pixels ? pixel_x[13:5] : {1'b0, pixel_x[13:6]};
  assign tile_y  = pixel_y[12:5];
  assign odd_row = tile_y[0];
  assign col_rev = row_tiles - tile_x - 9'd1;

  // 1K sub-tile placement, order depends on row parity
  assign sub_idx = {pixel_y[4], (wide_pixels ? pixel_x[4] : pixel_x[5])};
  assign sub_pos = odd_row ? order_odd(sub_idx) : order_even(sub_idx);

  // 64 byte micro-tile and pixel within it
  assign micro_x = wide_pixels ? pixel_x[3:2] : pixel_x[4:3];
  assign micro_y = pixel_y[3:2];
  assign inner   = wide_pixels ? {pixel_y[1:0], pixel_x[1:0], 2'b00}
                               : {pixel_y[1:0], pixel_x[2:0], 1'b0};

  // classified item
  always_comb begin
    item.x_out_of_row = ({1'b0, pixel_x} >= row_limit);
    item.tile_row     = tile_y;
    item.tile_col     = odd_row ? col_rev[TILE_COL_W-1:0] : tile_x[TILE_COL_W-1:0];
    item.low_offset   = {sub_pos, micro_y, micro_x, inner};
  end

endmodule

// ----- rtl/core/tfa_queue.sv -----
// two-entry queue between front and back
`timescale 1ns / 1ps
module tfa_queue
  import tfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tfa_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output tfa_item_t head_item
);

  tfa_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_item = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/tfa_back.sv -----
// back end: forms the tile number and registers the final byte offset
`timescale 1ns / 1ps
module tfa_back
  import tfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  tfa_item_t           item,
  input  logic [ROW_W-1:0]    row_tiles,
  output logic                out_valid,
  output logic [OFFSET_W-1:0] out_byte_offset,
  output logic                out_x_out_of_row
);

  logic [TILE_ROW_W+ROW_W-1:0] row_base;
  logic [TILE_ROW_W+ROW_W-1:0] tile_num;
  logic [OFFSET_W-1:0]         offset_nxt;
  logic                        valid_r;
  logic [OFFSET_W-1:0]         offset_r;
  logic                        oor_r;

  // tile number = tile_row * row_tiles + column, 4K bytes each
  assign row_base   = item.tile_row * row_tiles;
  assign tile_num   = row_base + {{(TILE_ROW_W+ROW_W-TILE_COL_W){1'b0}}, item.tile_col};
  assign offset_nxt = item.x_out_of_row ? '0
                                        : {tile_num[TILE_NUM_W-1:0], item.low_offset};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_valid) begin
      offset_r <= offset_nxt;
      oor_r    <= item.x_out_of_row;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte_offset  = offset_r;
  assign out_x_out_of_row = oor_r;

endmodule

// ----- rtl/core/t_format_tiled_address_unit.sv -----
// top level of the T-format tiled surface address unit
// path: a transferred coordinate is written into the queue, then the back end registers
//   its result, which is shown with out_valid
// throughput: one coordinate per cycle; the back end drains the queue every cycle
// reset: synchronous active-low; clears queue and strobe, wide_pixels=1, tiles_per_row=1
// results cannot be stalled by the receiver, so busy stays low in operation
`timescale 1ns / 1ps
module t_format_tiled_address_unit
  import tfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [X_W-1:0]       in_pixel_x,
  input  logic [Y_W-1:0]       in_pixel_y,
  output logic                 out_valid,
  output logic [OFFSET_W-1:0]  out_byte_offset,
  output logic                 out_x_out_of_row,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  logic             wide_pixels_r;
  logic [ROW_W-1:0] tiles_per_row_r;
  logic [ROW_W-1:0] row_tiles;
  logic             accept;
  logic             q_full;
  logic             q_not_empty;
  tfa_item_t        front_item;
  tfa_item_t        head_item;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_pixels_r   <= 1'b1;
      tiles_per_row_r <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDE_PIXELS) begin
        wide_pixels_r <= cfg_data[0];
      end else if (cfg_index == CFG_TILES_PER_ROW) begin
        tiles_per_row_r <= cfg_data;
      end
    end
  end

  // saturate row width
  assign row_tiles = (tiles_per_row_r > MAX_ROW_TILES) ? MAX_ROW_TILES : tiles_per_row_r;

  // input transfer
  assign busy   = q_full;
  assign accept = start && !busy;

  tfa_front u_front (
    .wide_pixels (wide_pixels_r),
    .row_tiles   (row_tiles),
    .pixel_x     (in_pixel_x),
    .pixel_y     (in_pixel_y),
    .item        (front_item)
  );

  tfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_not_empty),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  tfa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (q_not_empty),
    .item             (head_item),
    .row_tiles        (row_tiles),
    .out_valid        (out_valid),
    .out_byte_offset  (out_byte_offset),
    .out_x_out_of_row (out_x_out_of_row)
  );

  // queue never backs up since the back end takes an item every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled up");

  // every transfer yields a result once it has passed the queue and the back-end register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result missing after transfer");

  // a result is only valid if the queue held an item when the back end registered it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_not_empty))
    else $error("result without queued item");

  // out-of-row results carry a zero offset
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_x_out_of_row) |-> (out_byte_offset == '0))
    else $error("nonzero offset on out-of-row result");

endmodule
